/* src/psm_pkg.sv */
// Shared types and codes for the paged sparse memory.
`timescale 1ns / 1ps
`default_nettype none
package psm_pkg;

  localparam int LANES       = 8;
  localparam int CMD_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH = 4;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_EXISTS = 2'd2;

  // back-end operations
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]            op;
    logic [1:0]            status;
    logic [2:0]            base;
    logic [LANES-1:0]      en;
    logic [LANES-1:0][7:0] wbytes;
  } cmd_t;

endpackage
`default_nettype wire

/* src/psm_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module psm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/psm_fifo.sv */
// Small register FIFO with occupancy count.
`timescale 1ns / 1ps
`default_nettype none
module psm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = cnt_r;

endmodule
`default_nettype wire

/* src/psm_front.sv */
// Front end: page present map and request classification into lane commands.
`timescale 1ns / 1ps
`default_nettype none
module psm_front #(
  parameter int ADDR_WIDTH = 16,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [1:0]            kind,
  input  wire logic [15:0]           address,
  input  wire logic [1:0]            size_code,
  input  wire logic [63:0]           write_data,
  output psm_pkg::cmd_t              cmd,
  output logic      [ADDR_WIDTH-4:0] cmd_row
);

  import psm_pkg::*;

  localparam int PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int PN_W      = ADDR_WIDTH - PAGE_BITS;
  localparam int ROW_W     = ADDR_WIDTH - 3;
  localparam int RPB       = PAGE_BITS - 3;
  localparam int PAGES     = 2**PN_W;

  logic [PAGES-1:0]      present_r, present_nxt;
  logic [ADDR_WIDTH-1:0] addr;
  logic [ROW_W-1:0]      row0;
  logic [PN_W-1:0]       first_page;
  logic                  first_present;

  assign addr          = ADDR_WIDTH'(address);
  assign row0          = addr[ADDR_WIDTH-1:3];
  assign first_page    = addr[ADDR_WIDTH-1:PAGE_BITS];
  assign first_present = present_r[first_page];
  assign cmd_row       = row0;

  always_comb begin
    logic [2:0]       off;
    logic [ROW_W-1:0] row_i;
    logic             active;
    cmd        = '0;
    cmd.base   = addr[2:0];
    for (int i = 0; i < LANES; i++) begin
      off            = 3'(i) - addr[2:0];
      row_i          = row0 + ROW_W'(3'(i) < addr[2:0]);
      active         = {1'b0, off} < (4'd1 << size_code);
      cmd.en[i]      = active && present_r[row_i[ROW_W-1:RPB]];
      cmd.wbytes[i]  = write_data[{off, 3'b000} +: 8];
    end
    case (kind)
      KIND_ADD: begin
        cmd.en     = '0;
        cmd.op     = first_present ? OP_NONE : OP_CLEAR;
        cmd.status = first_present ? ST_EXISTS : ST_OK;
      end
      KIND_READ: begin
        cmd.op     = OP_READ;
        cmd.status = first_present ? ST_OK : ST_ABSENT;
      end
      KIND_WRITE: begin
        cmd.op     = first_present ? OP_WRITE : OP_NONE;
        cmd.status = first_present ? ST_OK : ST_ABSENT;
      end
      default: begin
        cmd.en     = '0;
        cmd.op     = OP_NONE;
        cmd.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    present_nxt = present_r;
    if (accept && kind == KIND_ADD) begin
      present_nxt[first_page] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else begin
      present_r <= present_nxt;
    end
  end

`ifndef SYNTHESIS
  a_add_sets_present: assert property (@(posedge clk) disable iff (!rst_n)
    accept && kind == KIND_ADD |=> present_r[$past(first_page)])
    else $error("added page not marked present");

  a_clear_only_absent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd.op == OP_CLEAR |-> !first_present && kind == KIND_ADD)
    else $error("page fill issued for a present page");
`endif

endmodule
`default_nettype wire

/* src/psm_back.sv */
// Back end: eight byte-lane RAMs, page zero fill and result formation.
`timescale 1ns / 1ps
`default_nettype none
module psm_back #(
  parameter int ADDR_WIDTH = 16,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cmd_valid,
  input  wire psm_pkg::cmd_t                          cmd,
  input  wire logic [ADDR_WIDTH-4:0]                  cmd_row,
  output logic                                        cmd_pop,
  input  wire logic [$clog2(psm_pkg::OUT_Q_DEPTH+1)-1:0] out_count,
  output logic                                        res_push,
  output logic      [63:0]                            res_data,
  output logic      [1:0]                             res_status
);

  import psm_pkg::*;

  localparam int PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int PN_W      = ADDR_WIDTH - PAGE_BITS;
  localparam int ROW_W     = ADDR_WIDTH - 3;
  localparam int RPB       = PAGE_BITS - 3;
  localparam int OC_W      = $clog2(OUT_Q_DEPTH+1);

  logic                  clr_r, clr_nxt;
  logic [RPB-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [PN_W-1:0]       clr_page_r, clr_page_nxt;
  logic                  res_v_r;
  logic                  res_rd_r;
  logic [2:0]            res_base_r;
  logic [LANES-1:0]      res_en_r;
  logic [1:0]            res_status_r;
  logic                  issue;
  logic [LANES-1:0]      lane_we;
  logic [ROW_W-1:0]      lane_addr [LANES];
  logic [7:0]            lane_wdata [LANES];
  logic [7:0]            lane_rdata [LANES];

  assign issue = cmd_valid && !clr_r &&
                 (({1'b0, out_count} + (OC_W+1)'(res_v_r)) < (OC_W+1)'(OUT_Q_DEPTH));
  assign cmd_pop = issue;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (clr_r) begin
        lane_we[i]    = 1'b1;
        lane_addr[i]  = {clr_page_r, clr_cnt_r};
        lane_wdata[i] = '0;
      end else begin
        lane_we[i]    = issue && cmd.op == OP_WRITE && cmd.en[i];
        lane_addr[i]  = cmd_row + ROW_W'(3'(i) < cmd.base);
        lane_wdata[i] = cmd.wbytes[i];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    psm_ram #(
      .WIDTH (8),
      .DEPTH (2**ROW_W)
    ) u_ram (
      .clk   (clk),
      .we    (lane_we[g]),
      .addr  (lane_addr[g]),
      .wdata (lane_wdata[g]),
      .rdata (lane_rdata[g])
    );
  end

  always_comb begin
    clr_nxt      = clr_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_page_nxt = clr_page_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == '1) begin
        clr_nxt = 1'b0;
      end
    end else if (issue && cmd.op == OP_CLEAR) begin
      clr_nxt      = 1'b1;
      clr_cnt_nxt  = '0;
      clr_page_nxt = cmd_row[ROW_W-1:RPB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      clr_r   <= clr_nxt;
      res_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    clr_cnt_r  <= clr_cnt_nxt;
    clr_page_r <= clr_page_nxt;
    if (issue) begin
      res_rd_r     <= cmd.op == OP_READ;
      res_base_r   <= cmd.base;
      res_en_r     <= cmd.en;
      res_status_r <= cmd.status;
    end
  end

  // lane data back to little-endian byte order
  always_comb begin
    logic [2:0] lane;
    res_data = '0;
    for (int n = 0; n < LANES; n++) begin
      lane = res_base_r + 3'(n);
      if (res_rd_r && res_en_r[lane]) begin
        res_data[8*n +: 8] = lane_rdata[lane];
      end
    end
  end

  assign res_push   = res_v_r;
  assign res_status = res_status_r;

`ifndef SYNTHESIS
  a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r |-> out_count < OC_W'(OUT_Q_DEPTH))
    else $error("result pushed into a full output queue");

  a_fill_start: assert property (@(posedge clk) disable iff (!rst_n)
    issue && cmd.op == OP_CLEAR |=> clr_r && clr_cnt_r == '0)
    else $error("page fill did not start");
`endif

endmodule
`default_nettype wire

/* src/paged_sparse_memory.sv */
// Top level of the paged sparse memory: front end, request queue, back end, result queue.
`timescale 1ns / 1ps
`default_nettype none
// Byte-addressed memory of 2^ADDR_WIDTH bytes in pages of PAGE_BYTES bytes, held in
// eight byte-lane RAMs so that any 1, 2, 4 or 8 byte access, aligned or not, is served
// by one access to each lane RAM. Reads, writes, refused requests and add-page requests
// for a present page issue back to back: one request per cycle is sustained while the
// result queue has room and no page fill runs; a request passes the request queue, the
// registered RAM read and the result queue before its result can be popped. An add-page
// request for an absent page zeroes the page one 8-byte row per cycle, occupying the
// back end while the two-entry request queue takes requests until it fills. The present
// map is cleared at reset; the RAMs need no clearing pass.
module paged_sparse_memory #(
  parameter int ADDR_WIDTH = 16,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_address,
  input  wire logic [1:0]  in_size_code,
  input  wire logic [63:0] in_write_data,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic      [63:0] out_read_data,
  output logic      [1:0]  out_status
);

  import psm_pkg::*;

  localparam int ROW_W = ADDR_WIDTH - 3;
  localparam int CQ_W  = $bits(cmd_t) + ROW_W;
  localparam int OQ_W  = 66;

  logic                               in_acc;
  cmd_t                               f_cmd;
  logic [ROW_W-1:0]                   f_row;
  logic [CQ_W-1:0]                    cq_rdata;
  logic [$clog2(CMD_Q_DEPTH+1)-1:0]   cq_count;
  logic                               cq_pop;
  cmd_t                               b_cmd;
  logic [ROW_W-1:0]                   b_row;
  logic [$clog2(OUT_Q_DEPTH+1)-1:0]   oq_count;
  logic                               res_push;
  logic [63:0]                        res_data;
  logic [1:0]                         res_status;
  logic [OQ_W-1:0]                    oq_rdata;

  assign in_full = cq_count == ($clog2(CMD_Q_DEPTH+1))'(CMD_Q_DEPTH);
  assign in_acc  = in_push && !in_full;

  psm_front #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .kind       (in_kind),
    .address    (in_address),
    .size_code  (in_size_code),
    .write_data (in_write_data),
    .cmd        (f_cmd),
    .cmd_row    (f_row)
  );

  psm_fifo #(
    .WIDTH (CQ_W),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc),
    .wdata ({f_cmd, f_row}),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .count (cq_count)
  );

  assign b_cmd = cq_rdata[CQ_W-1:ROW_W];
  assign b_row = cq_rdata[ROW_W-1:0];

  psm_back #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cq_count != '0),
    .cmd        (b_cmd),
    .cmd_row    (b_row),
    .cmd_pop    (cq_pop),
    .out_count  (oq_count),
    .res_push   (res_push),
    .res_data   (res_data),
    .res_status (res_status)
  );

  psm_fifo #(
    .WIDTH (OQ_W),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_data, res_status}),
    .pop   (out_pop && !out_empty),
    .rdata (oq_rdata),
    .count (oq_count)
  );

  assign out_empty     = oq_count == '0;
  assign out_read_data = oq_rdata[OQ_W-1:2];
  assign out_status    = oq_rdata[1:0];

endmodule
`default_nettype wire

/* sim/tb_paged_sparse_memory.sv */
// Self-checking testbench for the paged sparse memory, with its own shadow memory model.
`timescale 1ns / 1ps
module tb_paged_sparse_memory;
  import psm_pkg::*;

  localparam int PAGE_BYTES = 4096;
  localparam int MEM_BYTES  = 65536;
  localparam int PAGE_COUNT = MEM_BYTES / PAGE_BYTES;

  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [1:0] SIZE_1B = 2'd0;
  localparam logic [1:0] SIZE_2B = 2'd1;
  localparam logic [1:0] SIZE_4B = 2'd2;
  localparam logic [1:0] SIZE_8B = 2'd3;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  typedef struct packed {
    logic [63:0] read_data;
    logic [1:0]  status;
  } mem_response_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_kind = '0;
  logic [15:0] in_address = '0;
  logic [1:0]  in_size_code = '0;
  logic [63:0] in_write_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [63:0] out_read_data;
  logic [1:0]  out_status;

  logic [7:0]    shadow_bytes [0:MEM_BYTES-1];
  bit            shadow_present [0:PAGE_COUNT-1];
  mem_response_t pending_responses [$];
  int            errors = 0;

  paged_sparse_memory uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_kind      (in_kind),
    .in_address   (in_address),
    .in_size_code (in_size_code),
    .in_write_data(in_write_data),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_read_data(out_read_data),
    .out_status   (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow memory: applies one request and returns its response
  function automatic mem_response_t apply_memory_request(logic [1:0] kind, logic [15:0] addr,
                                                         logic [1:0] size, logic [63:0] wdata);
    mem_response_t resp;
    logic [15:0]   a;
    int            nbytes;
    int            pg;
    resp.read_data = '0;
    resp.status    = ST_OK;
    nbytes         = 1 << size;
    pg             = addr / PAGE_BYTES;
    case (kind)
      KIND_ADD: begin
        if (shadow_present[pg]) begin
          resp.status = ST_EXISTS;
        end else begin
          for (int i = 0; i < PAGE_BYTES; i++) shadow_bytes[pg * PAGE_BYTES + i] = 8'h00;
          shadow_present[pg] = 1'b1;
        end
      end
      KIND_READ: begin
        if (!shadow_present[pg]) resp.status = ST_ABSENT;
        for (int n = 0; n < nbytes; n++) begin
          a = addr + n[15:0];
          if (shadow_present[a / PAGE_BYTES]) resp.read_data[8*n +: 8] = shadow_bytes[a];
        end
      end
      KIND_WRITE: begin
        if (!shadow_present[pg]) begin
          resp.status = ST_ABSENT;
        end else begin
          for (int n = 0; n < nbytes; n++) begin
            a = addr + n[15:0];
            if (shadow_present[a / PAGE_BYTES]) shadow_bytes[a] = wdata[8*n +: 8];
          end
        end
      end
      default: ;
    endcase
    return resp;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [15:0] addr,
                              input logic [1:0] size, input logic [63:0] wdata);
    @(negedge clk);
    in_push       <= 1'b1;
    in_kind       <= kind;
    in_address    <= addr;
    in_size_code  <= size;
    in_write_data <= wdata;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_responses.push_back(apply_memory_request(kind, addr, size, wdata));
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic test_absent_pages();
    send_request(KIND_READ, 16'h0000, SIZE_8B, 64'h0);
    send_request(KIND_WRITE, 16'h1234, SIZE_4B, 64'h0123_4567_89ab_cdef);
    send_request(KIND_READ, 16'hffff, SIZE_1B, 64'h0);
  endtask

  task automatic test_add_page();
    send_request(KIND_ADD, 16'h0800, SIZE_8B, ALL_ONES);
    send_request(KIND_ADD, 16'h0fff, SIZE_1B, 64'h0);
    send_request(KIND_ADD, 16'hffff, SIZE_2B, 64'h0);
    send_request(KIND_ADD, 16'hf000, SIZE_4B, 64'h0);
  endtask

  // wrap at the top address and requests straddling present/absent pages
  task automatic test_wrap_and_span();
    send_request(KIND_WRITE, 16'hfffc, SIZE_8B, 64'h8877_6655_4433_2211);
    send_request(KIND_READ, 16'hfffe, SIZE_4B, 64'h0);
    send_request(KIND_WRITE, 16'h0ffe, SIZE_8B, ALL_ONES);
    send_request(KIND_READ, 16'h0ffc, SIZE_8B, 64'h0);
    send_request(KIND_READ, 16'h1000, SIZE_1B, 64'h0);
    send_request(KIND_ADD, 16'h1fff, SIZE_1B, 64'h0);
    send_request(KIND_READ, 16'h0ffc, SIZE_8B, 64'h0);
    send_request(KIND_WRITE, 16'h7ffe, SIZE_8B, ALL_ONES);
    send_request(KIND_READ, 16'h6ffd, SIZE_8B, 64'h0);
    send_request(KIND_READ, 16'hefff, SIZE_4B, 64'h0);
  endtask

  task automatic test_sizes();
    send_request(KIND_WRITE, 16'h0000, SIZE_1B, ALL_ONES);
    send_request(KIND_WRITE, 16'h0001, SIZE_2B, 64'h0);
    send_request(KIND_WRITE, 16'h0003, SIZE_4B, {$urandom, $urandom});
    send_request(KIND_READ, 16'h0000, SIZE_8B, 64'h0);
    send_request(KIND_WRITE, 16'h0100, SIZE_8B, ALL_ONES);
    send_request(KIND_READ, 16'h0101, SIZE_2B, 64'h0);
  endtask

  task automatic test_unused_kind();
    send_request(KIND_NONE, 16'hffff, SIZE_8B, ALL_ONES);
    send_request(KIND_NONE, 16'h0000, SIZE_1B, 64'h0);
  endtask

  // mostly traffic to present pages; pages 8 and 13 are never added
  task automatic test_random_traffic();
    int          r;
    int          sel;
    int          pg;
    int          cnt;
    int          idx;
    bit          burst;
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [63:0] wdata;
    burst = 1'b0;
    for (int k = 0; k < 1500; k++) begin
      if (k % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) kind = KIND_WRITE;
      else if (r < 90) kind = KIND_READ;
      else if (r < 97) kind = KIND_ADD;
      else kind = KIND_NONE;
      sel = $urandom_range(0, 99);
      if (kind == KIND_ADD) begin
        pg = $urandom_range(0, PAGE_COUNT - 1);
        if (pg == 8 || pg == 13) pg = pg - 1;
        addr = 16'(pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
      end else if (sel < 15) begin
        addr = 16'($urandom);
      end else begin
        cnt = 0;
        for (int i = 0; i < PAGE_COUNT; i++) if (shadow_present[i]) cnt++;
        idx = $urandom_range(0, cnt - 1);
        pg  = 0;
        for (int i = 0; i < PAGE_COUNT; i++) begin
          if (shadow_present[i]) begin
            if (idx == 0) pg = i;
            idx--;
          end
        end
        if (sel < 35) addr = 16'((pg + 1) * PAGE_BYTES - $urandom_range(1, 8));
        else addr = 16'(pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
      end
      r = $urandom_range(0, 9);
      if (r == 0) wdata = 64'h0;
      else if (r == 1) wdata = ALL_ONES;
      else wdata = {$urandom, $urandom};
      send_request(kind, addr, 2'($urandom_range(0, 3)), wdata);
      if (!burst) hold_off(pick_gap());
    end
  endtask

  initial begin : pop_driver
    int n;
    forever begin
      @(negedge clk);
      out_pop <= 1'b1;
      repeat ($urandom_range(0, 40)) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_responses
    mem_response_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_responses.size() == 0) begin
        $error("unexpected response: read_data %h status %0d", out_read_data, out_status);
        errors++;
      end else begin
        want = pending_responses.pop_front();
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_read_data);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_absent_pages();
    test_add_page();
    test_wrap_and_span();
    test_sizes();
    test_unused_kind();
    test_random_traffic();
    hold_off(1);
    while (pending_responses.size() != 0) @(posedge clk);
    // a page clear may still be running in the back end
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
